/* rtl/tccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants for the text console
// Screen geometry, control codes, cursor struct and controller states.
// ----------------------------------------------------------------------------
package tccs_pkg;

   localparam int ROWS   = 25;
   localparam int COLS   = 80;
   localparam int NCELLS = ROWS * COLS;

   localparam int ColW  = $clog2(COLS);
   localparam int RowW  = $clog2(ROWS);
   localparam int AddrW = $clog2(NCELLS);

   localparam logic [7:0]  CH_BLANK     = 8'h20;
   localparam logic [7:0]  CH_TAB       = 8'h09;
   localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
   localparam logic [7:0]  CH_BACKSPACE = 8'h08;
   localparam logic [7:0]  COLOR_RESET  = 8'h07;
   localparam logic [15:0] CELL_RESET   = 16'h0720;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            scroll;
   } cursor_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

/* rtl/tccs_cursor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_cursor: cursor advance for one put
// Column step with wrap, then newline, tab and backspace handling, and the
// scroll decision when the row runs past the bottom line.
// ----------------------------------------------------------------------------
module tccs_cursor (
   input  logic [tccs_pkg::ColW-1:0] col,
   input  logic [tccs_pkg::RowW-1:0] row,
   input  logic [7:0]                ch,
   output tccs_pkg::cursor_type      nxt
);
   import tccs_pkg::*;

   localparam logic [ColW:0]   COLS_C = (ColW + 1)'(COLS);
   localparam logic [RowW+1:0] ROWS_C = (RowW + 2)'(ROWS);

   logic [ColW:0]   col_step;
   logic            wrap_a;
   logic [ColW:0]   col_a;
   logic [RowW+1:0] row_a;
   logic [ColW:0]   tab_round;
   logic [ColW:0]   tab_step;
   logic            wrap_b;
   logic [ColW:0]   col_f;
   logic [RowW+1:0] row_f;

   always_comb begin
      col_step  = {1'b0, col} + (ColW + 1)'(1);
      wrap_a    = (col_step >= COLS_C);
      col_a     = wrap_a ? '0 : col_step;
      row_a     = {2'b00, row} + (RowW + 2)'(wrap_a);
      tab_round = (col_a + (ColW + 1)'(7)) & ~(ColW + 1)'(7);
      tab_step  = tab_round + (ColW + 1)'(1);
      wrap_b    = (tab_step >= COLS_C);
      col_f     = col_a;
      row_f     = row_a;
      case (ch)
         CH_NEWLINE: begin
            col_f = '0;
            row_f = row_a + (RowW + 2)'(1);
         end
         CH_TAB: begin
            col_f = wrap_b ? '0 : tab_step;
            row_f = row_a + (RowW + 2)'(wrap_b);
         end
         CH_BACKSPACE: begin
            col_f = (col_a >= (ColW + 1)'(2)) ? col_a - (ColW + 1)'(2) : '0;
         end
         default: begin
            col_f = col_a;
         end
      endcase
      nxt.col    = col_f[ColW-1:0];
      nxt.scroll = (row_f >= ROWS_C);
      nxt.row    = nxt.scroll ? RowW'(ROWS - 1) : row_f[RowW-1:0];
   end

endmodule

/* rtl/text_console_cursor_scroll_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit: text screen with cursor and scrolling
// Screen cells live in one synchronous RAM; puts write at the cursor, reads
// return one cell, and a scroll copies the screen up one row by a RAM sweep.
//
//   channel  dir  handshake          word
//   req_     in   valid / stall      operation, character, read_index
//   rsp_     out  valid / stall      cursor_col, cursor_row, cell_data
//   csr_     in   valid / ready      text color attribute byte
//
// A put that scrolls copies each row up by one and then blanks the bottom row,
// writing every RAM cell once through the write port.
// After reset a clearing pass fills the RAM with blanks; req_stall is high
// meanwhile.
// A finished word sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_character,
   input  logic [10:0] req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_cell_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import tccs_pkg::*;

   localparam logic [AddrW-1:0] LAST_CELL = AddrW'(NCELLS - 1);
   localparam logic [AddrW-1:0] COPY_LAST = AddrW'((ROWS - 1) * COLS - 1);
   localparam logic [AddrW-1:0] FILL_FIRST = AddrW'((ROWS - 1) * COLS);
   localparam logic [AddrW-1:0] COLS_A = AddrW'(COLS);

   logic [15:0] mem [NCELLS];

   state_type        state_ff, state_in;
   logic [AddrW-1:0] cnt_ff, cnt_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic             scroll_ff, scroll_in;
   logic [7:0]       color_ff;
   logic             rd_sel_ff, rd_sel_in;
   logic [15:0]      rd_data_ff;
   logic             wr_v_ff, wr_v_in;
   logic [AddrW-1:0] wr_addr_ff, wr_addr_in;
   logic [15:0]      wr_data_ff, wr_data_in;
   logic             wr_copy_ff, wr_copy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_col_ff;
   logic [4:0]       rsp_row_ff;
   logic [15:0]      rsp_data_ff;

   logic             req_take;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic             load_rsp;
   logic [AddrW-1:0] put_addr;
   logic             idx_ok;
   cursor_type       cur_nxt;

   tccs_cursor u_cursor (
      .col (col_ff),
      .row (row_ff),
      .ch  (req_character),
      .nxt (cur_nxt)
   );

   assign req_stall = (state_ff != ST_IDLE) | wr_v_ff;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign put_addr  = AddrW'(AddrW'(row_ff) * COLS_A) + AddrW'(col_ff);
   assign idx_ok    = (32'(req_read_index) < NCELLS);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      scroll_in  = scroll_ff;
      rd_sel_in  = rd_sel_ff;
      rd_en      = 1'b0;
      rd_addr    = cnt_ff + COLS_A;
      wr_v_in    = 1'b0;
      wr_addr_in = cnt_ff;
      wr_data_in = {color_ff, CH_BLANK};
      wr_copy_in = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_v_in    = 1'b1;
            wr_data_in = CELL_RESET;
            cnt_in     = cnt_ff + AddrW'(1);
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (op_type'(req_operation) == OP_READ) begin
                  rd_en     = idx_ok;
                  rd_addr   = AddrW'(req_read_index);
                  rd_sel_in = idx_ok;
                  state_in  = ST_RESP;
               end else begin
                  wr_v_in    = 1'b1;
                  wr_addr_in = put_addr;
                  wr_data_in = {color_ff, req_character};
                  col_in     = cur_nxt.col;
                  row_in     = cur_nxt.row;
                  scroll_in  = cur_nxt.scroll;
                  rd_sel_in  = 1'b0;
                  state_in   = ST_PUT;
               end
            end
         end
         ST_PUT: begin
            cnt_in   = '0;
            state_in = scroll_ff ? ST_SCROLL : ST_RESP;
         end
         ST_SCROLL: begin
            rd_en      = 1'b1;
            wr_v_in    = 1'b1;
            wr_copy_in = 1'b1;
            cnt_in     = cnt_ff + AddrW'(1);
            if (cnt_ff == COPY_LAST) begin
               cnt_in   = FILL_FIRST;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            wr_v_in = 1'b1;
            cnt_in  = cnt_ff + AddrW'(1);
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         scroll_ff    <= 1'b0;
         rd_sel_ff    <= 1'b0;
         wr_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scroll_ff    <= scroll_in;
         rd_sel_ff    <= rd_sel_in;
         wr_v_ff      <= wr_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            color_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      wr_copy_ff <= wr_copy_in;
      if (load_rsp) begin
         rsp_col_ff  <= 7'(col_ff);
         rsp_row_ff  <= 5'(row_ff);
         rsp_data_ff <= rd_sel_ff ? rd_data_ff : 16'h0000;
      end
   end

   // screen RAM: one write port fed by the write stage, one registered read
   always_ff @(posedge clock) begin
      if (wr_v_ff) begin
         mem[wr_addr_ff] <= wr_copy_ff ? rd_data_ff : wr_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS)
      else $error("cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < COLS)
      else $error("cursor column out of range");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (32'(row_ff) == ROWS - 1))
      else $error("scroll with cursor off the bottom line");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("output word overwritten while held");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !wr_v_ff)
      else $error("word taken with a RAM write in flight");

endmodule
